FILE: design/nand_page_read_sequencer_unit_defines.svh
// Assertion macros for the NAND page read sequencer.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef NAND_PAGE_READ_SEQUENCER_UNIT_DEFINES_SVH
`define NAND_PAGE_READ_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define NPR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("npr assertion failed");

// next-cycle implication
`define NPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("npr assertion failed");

`endif

FILE: design/npr_pkg.sv
// Shared types and constants for the NAND page read sequencer.
// No dependencies; used by npr_emitter and nand_page_read_sequencer_unit.
package npr_pkg;

   // page size must be a power of two (512 .. 4096)
   localparam int PAGE_BYTES = 2048;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int COL_W      = PAGE_SHIFT + 1;

   typedef logic [COL_W-1:0] col_type;

   localparam logic [1:0] FUNC_START  = 2'd0;
   localparam logic [1:0] FUNC_STATUS = 2'd1;
   localparam logic [1:0] FUNC_DATA   = 2'd2;

   localparam logic [2:0] ACT_SELECT   = 3'd0;
   localparam logic [2:0] ACT_CMD      = 3'd1;
   localparam logic [2:0] ACT_ADDR     = 3'd2;
   localparam logic [2:0] ACT_STORE    = 3'd3;
   localparam logic [2:0] ACT_DESELECT = 3'd4;

   localparam logic [7:0] CMD_READ0      = 8'h00;
   localparam logic [7:0] CMD_READ_START = 8'h30;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_WAIT = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   typedef enum logic [4:0] {
      KIND_START_ZERO  = 5'b00001,
      KIND_START_OPEN  = 5'b00010,
      KIND_STORE_ONLY  = 5'b00100,
      KIND_STORE_DESEL = 5'b01000,
      KIND_STORE_OPEN  = 5'b10000
   } kind_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] start_address;
      logic [31:0] length;
      logic        ready_req;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  value;
      logic [31:0] buffer_index;
      logic        last;
   } rsp_type;

   // result burst handed from the sequencer to the emitter
   typedef struct packed {
      kind_type    kind;
      logic [31:0] addr;
      logic [7:0]  data;
      logic [31:0] index;
   } burst_type;

endpackage

FILE: design/npr_emitter.sv
// Result emitter: holds one burst and sends its transactions one per cycle while rsp_stall is low.
// Depends on npr_pkg.
module npr_emitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  npr_pkg::burst_type burst,
   output logic               ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output npr_pkg::rsp_type   rsp_data
);

   logic               valid_ff, valid_in;
   logic [2:0]         step_ff, step_in;
   npr_pkg::burst_type burst_ff;
   logic               final_step;
   logic [15:0]        col;
   logic [31:0]        row;

   assign col = 16'(burst_ff.addr[npr_pkg::PAGE_SHIFT-1:0]);
   assign row = burst_ff.addr >> npr_pkg::PAGE_SHIFT;

   always_comb begin
      case (burst_ff.kind)
         npr_pkg::KIND_START_ZERO,
         npr_pkg::KIND_STORE_DESEL: final_step = (step_ff == 3'd1);
         npr_pkg::KIND_START_OPEN,
         npr_pkg::KIND_STORE_OPEN:  final_step = (step_ff == 3'd7);
         default:                   final_step = (step_ff == 3'd0);
      endcase
   end

   assign ready     = !valid_ff || (!rsp_stall && final_step);
   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_data              = '0;
      rsp_data.last         = final_step;
      if (step_ff == 3'd0) begin
         if (burst_ff.kind inside {npr_pkg::KIND_START_ZERO, npr_pkg::KIND_START_OPEN}) begin
            rsp_data.action = npr_pkg::ACT_SELECT;
         end else begin
            rsp_data.action       = npr_pkg::ACT_STORE;
            rsp_data.value        = burst_ff.data;
            rsp_data.buffer_index = burst_ff.index;
         end
      end else if (burst_ff.kind inside {npr_pkg::KIND_START_ZERO,
                                         npr_pkg::KIND_STORE_DESEL}) begin
         rsp_data.action = npr_pkg::ACT_DESELECT;
      end else begin
         case (step_ff)
            3'd1: begin
               rsp_data.action = npr_pkg::ACT_CMD;
               rsp_data.value  = npr_pkg::CMD_READ0;
            end
            3'd2: begin
               rsp_data.action = npr_pkg::ACT_ADDR;
               rsp_data.value  = col[7:0];
            end
            3'd3: begin
               rsp_data.action = npr_pkg::ACT_ADDR;
               rsp_data.value  = col[15:8];
            end
            3'd4: begin
               rsp_data.action = npr_pkg::ACT_ADDR;
               rsp_data.value  = row[7:0];
            end
            3'd5: begin
               rsp_data.action = npr_pkg::ACT_ADDR;
               rsp_data.value  = row[15:8];
            end
            3'd6: begin
               rsp_data.action = npr_pkg::ACT_ADDR;
               rsp_data.value  = row[23:16];
            end
            3'd7: begin
               rsp_data.action = npr_pkg::ACT_CMD;
               rsp_data.value  = npr_pkg::CMD_READ_START;
            end
            default: begin
               rsp_data.action = npr_pkg::ACT_SELECT;
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      step_in  = step_ff;
      if (load) begin
         valid_in = 1'b1;
         step_in  = 3'd0;
      end else if (valid_ff && !rsp_stall) begin
         if (final_step) begin
            valid_in = 1'b0;
            step_in  = 3'd0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
      end
   end

endmodule

FILE: design/nand_page_read_sequencer_unit.sv
// Top level of the large-page NAND read sequencer.
// Depends on npr_pkg, npr_emitter and nand_page_read_sequencer_unit_defines.svh.
//
// Each accepted transaction updates the read state in the cycle it is taken and,
// if it causes results, loads one burst into the emitter, which sends them one per
// cycle while rsp_stall is low: a start gives 2 or 8 results, a data byte 1, 2 or 8,
// a status sample none. A new transaction is taken every cycle as long as the
// previous burst is done or its final result goes out with rsp_stall low, so plain
// data bytes stream at one per cycle. A longer burst, such as a page open, stalls
// the input until its final result is taken. req_stall follows the emitter (and
// rsp_stall).
`include "nand_page_read_sequencer_unit_defines.svh"

module nand_page_read_sequencer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  npr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output npr_pkg::rsp_type rsp_data
);

   npr_pkg::phase_type phase_ff, phase_in;
   logic [31:0]        cur_addr_ff, cur_addr_in;
   logic [31:0]        bytes_done_ff, bytes_done_in;
   logic [31:0]        total_ff, total_in;
   npr_pkg::col_type   col_ff, col_in;

   logic               accept;
   logic               emit_ready;
   logic               load;
   npr_pkg::burst_type burst;
   logic [31:0]        bytes_next;
   logic [31:0]        addr_next;
   npr_pkg::col_type   col_next;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = !emit_ready;
   assign bytes_next = bytes_done_ff + 32'd1;
   assign addr_next  = cur_addr_ff + 32'd1;
   assign col_next   = col_ff + npr_pkg::col_type'(1);

   always_comb begin
      phase_in      = phase_ff;
      cur_addr_in   = cur_addr_ff;
      bytes_done_in = bytes_done_ff;
      total_in      = total_ff;
      col_in        = col_ff;
      load          = 1'b0;
      burst.kind    = npr_pkg::KIND_STORE_ONLY;
      burst.addr    = req_data.start_address;
      burst.data    = req_data.data_byte;
      burst.index   = bytes_done_ff;
      if (accept) begin
         if (req_data.func == npr_pkg::FUNC_START && phase_ff == npr_pkg::PH_IDLE) begin
            cur_addr_in   = req_data.start_address;
            total_in      = req_data.length;
            bytes_done_in = 32'd0;
            col_in        = npr_pkg::col_type'(
                               req_data.start_address[npr_pkg::PAGE_SHIFT-1:0]);
            load          = 1'b1;
            if (req_data.length == 32'd0) begin
               burst.kind = npr_pkg::KIND_START_ZERO;
            end else begin
               burst.kind = npr_pkg::KIND_START_OPEN;
               phase_in   = npr_pkg::PH_WAIT;
            end
         end else if (req_data.func == npr_pkg::FUNC_STATUS &&
                      phase_ff == npr_pkg::PH_WAIT) begin
            if (req_data.ready_req) begin
               phase_in = npr_pkg::PH_DATA;
            end
         end else if (req_data.func == npr_pkg::FUNC_DATA &&
                      phase_ff == npr_pkg::PH_DATA) begin
            load          = 1'b1;
            bytes_done_in = bytes_next;
            cur_addr_in   = addr_next;
            col_in        = col_next;
            burst.addr    = addr_next;
            if (bytes_next == total_ff) begin
               burst.kind = npr_pkg::KIND_STORE_DESEL;
               phase_in   = npr_pkg::PH_IDLE;
            end else if (col_next >= npr_pkg::col_type'(npr_pkg::PAGE_BYTES)) begin
               burst.kind = npr_pkg::KIND_STORE_OPEN;
               col_in     = '0;
               phase_in   = npr_pkg::PH_WAIT;
            end else begin
               burst.kind = npr_pkg::KIND_STORE_ONLY;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= npr_pkg::PH_IDLE;
         cur_addr_ff   <= '0;
         bytes_done_ff <= '0;
         total_ff      <= '0;
         col_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         cur_addr_ff   <= cur_addr_in;
         bytes_done_ff <= bytes_done_in;
         total_ff      <= total_in;
         col_ff        <= col_in;
      end
   end

   npr_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .burst     (burst),
      .ready     (emit_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `NPR_ASSERT_NEXT(a_burst_continues, rsp_valid && !rsp_stall && !rsp_data.last, rsp_valid)
   `NPR_ASSERT_NEXT(a_start_selects, accept && req_data.func == npr_pkg::FUNC_START && phase_ff == npr_pkg::PH_IDLE, rsp_valid && rsp_data.action == npr_pkg::ACT_SELECT)
   `NPR_ASSERT_NOW(a_busy_has_length, phase_ff != npr_pkg::PH_IDLE, total_ff != 32'd0)

endmodule

FILE: tb/npr_read_checker.sv
`timescale 1ns / 1ps
// Checker for the NAND page read sequencer: tracks the read state per accepted request,
// predicts select/command/address/store/deselect actions and compares each response.
// Depends on npr_pkg; instantiated beside the block by nand_page_read_sequencer_unit_test.
module npr_read_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  npr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  npr_pkg::rsp_type rsp_data,
   output int               outstanding,
   output int               fail_count
);
   import npr_pkg::*;

   rsp_type     flash_actions[$];
   phase_type   read_phase;
   logic [31:0] read_addr;
   logic [31:0] bytes_stored;
   logic [31:0] read_length;
   logic [31:0] page_col;

   initial begin
      outstanding = 0;
      fail_count  = 0;
   end

   function automatic void push_action(logic [2:0] act, logic [7:0] val, logic [31:0] idx);
      rsp_type r;
      r.action       = act;
      r.value        = val;
      r.buffer_index = idx;
      r.last         = 1'b0;
      flash_actions.push_back(r);
   endfunction

   function automatic void push_page_open(logic [31:0] addr);
      logic [31:0] col;
      logic [31:0] row;
      col = addr % 32'(PAGE_BYTES);
      row = addr / 32'(PAGE_BYTES);
      push_action(ACT_CMD, CMD_READ0, '0);
      push_action(ACT_ADDR, col[7:0], '0);
      push_action(ACT_ADDR, col[15:8], '0);
      push_action(ACT_ADDR, row[7:0], '0);
      push_action(ACT_ADDR, row[15:8], '0);
      push_action(ACT_ADDR, row[23:16], '0);
      push_action(ACT_CMD, CMD_READ_START, '0);
   endfunction

   function automatic void advance_read(req_type t);
      int      n0;
      rsp_type tail;
      n0 = flash_actions.size();
      if (t.func == FUNC_START && read_phase == PH_IDLE) begin
         read_addr    = t.start_address;
         read_length  = t.length;
         bytes_stored = '0;
         page_col     = t.start_address % 32'(PAGE_BYTES);
         push_action(ACT_SELECT, '0, '0);
         if (t.length == '0) begin
            push_action(ACT_DESELECT, '0, '0);
         end else begin
            push_page_open(t.start_address);
            read_phase = PH_WAIT;
         end
      end else if (t.func == FUNC_STATUS && read_phase == PH_WAIT) begin
         if (t.ready_req) read_phase = PH_DATA;
      end else if (t.func == FUNC_DATA && read_phase == PH_DATA) begin
         push_action(ACT_STORE, t.data_byte, bytes_stored);
         bytes_stored = bytes_stored + 1;
         read_addr    = read_addr + 1;
         page_col     = page_col + 1;
         if (bytes_stored == read_length) begin
            push_action(ACT_DESELECT, '0, '0);
            read_phase = PH_IDLE;
         end else if (page_col >= 32'(PAGE_BYTES)) begin
            page_col = '0;
            push_page_open(read_addr);
            read_phase = PH_WAIT;
         end
      end
      if (flash_actions.size() > n0) begin
         tail = flash_actions[flash_actions.size() - 1];
         tail.last = 1'b1;
         flash_actions[flash_actions.size() - 1] = tail;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         flash_actions.delete();
         read_phase   = PH_IDLE;
         read_addr    = '0;
         bytes_stored = '0;
         read_length  = '0;
         page_col     = '0;
      end else begin
         if (req_valid && !req_stall) advance_read(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (flash_actions.size() == 0) begin
               $error("unexpected transaction: action %0d value %0h buffer_index %0h last %0b",
                      rsp_data.action, rsp_data.value, rsp_data.buffer_index, rsp_data.last);
               fail_count++;
            end else begin
               want = flash_actions.pop_front();
               if (rsp_data.action !== want.action) begin
                  $error("action: expected %0d, got %0d", want.action, rsp_data.action);
                  fail_count++;
               end
               if (rsp_data.value !== want.value) begin
                  $error("value: expected %0h, got %0h", want.value, rsp_data.value);
                  fail_count++;
               end
               if (rsp_data.buffer_index !== want.buffer_index) begin
                  $error("buffer_index: expected %0h, got %0h",
                         want.buffer_index, rsp_data.buffer_index);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
      end
      outstanding <= flash_actions.size();
   end

endmodule

FILE: tb/nand_page_read_sequencer_unit_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the NAND page read sequencer: directed and random read
// sequences with out-of-phase noise, random request gaps and response stalls.
// Depends on npr_pkg, nand_page_read_sequencer_unit and npr_read_checker.
module nand_page_read_sequencer_unit_test;
   import npr_pkg::*;

   localparam logic [1:0] FUNC_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS  = 275;
   localparam int         CYCLE_LIMIT   = 200000;
   localparam int         SETTLE_CYCLES = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      outstanding;
   int      fail_count;
   int      cycle_count  = 0;
   int      gap_pct      = 33;
   int      stall_pct    = 33;
   int      random_items = 0;

   always #6 clock = ~clock;

   nand_page_read_sequencer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   npr_read_checker read_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall   <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("nand_page_read_sequencer_unit verification failed");
         $finish;
      end
   end

   function automatic req_type random_req(logic [1:0] func);
      req_type t;
      t.func          = func;
      t.start_address = $urandom;
      t.length        = $urandom;
      t.ready_req     = 1'($urandom_range(1));
      t.data_byte     = 8'($urandom_range(255));
      return t;
   endfunction

   task automatic drive_req(req_type t);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // any func other than the one the current phase acts on
   task automatic send_noise(logic [1:0] live_func);
      logic [1:0] f;
      do f = 2'($urandom_range(3)); while (f == live_func);
      drive_req(random_req(f));
      random_items++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic read_sequence(logic [31:0] addr, logic [31:0] len, int noise_pct);
      req_type     t;
      logic [31:0] left;
      logic [31:0] col;
      logic [31:0] chunk;
      t = random_req(FUNC_START);
      t.start_address = addr;
      t.length        = len;
      drive_req(t);
      random_items++;
      left = len;
      col  = addr % 32'(PAGE_BYTES);
      while (left != 0) begin
         repeat ($urandom_range(2)) begin
            if ($urandom_range(99) < noise_pct) send_noise(FUNC_STATUS);
            t = random_req(FUNC_STATUS);
            t.ready_req = 1'b0;
            drive_req(t);
            random_items++;
         end
         if ($urandom_range(99) < noise_pct) send_noise(FUNC_STATUS);
         t = random_req(FUNC_STATUS);
         t.ready_req = 1'b1;
         drive_req(t);
         random_items++;
         chunk = 32'(PAGE_BYTES) - col;
         if (chunk > left) chunk = left;
         repeat (chunk) begin
            if ($urandom_range(99) < noise_pct) send_noise(FUNC_DATA);
            drive_req(random_req(FUNC_DATA));
            random_items++;
         end
         left = left - chunk;
         col  = '0;
      end
   endtask

   initial begin
      req_type     t;
      logic [31:0] addr;
      logic [31:0] len;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero length, then items ignored while idle
      t = random_req(FUNC_START);
      t.start_address = '0;
      t.length        = '0;
      drive_req(t);
      drive_req(random_req(FUNC_STATUS));
      drive_req(random_req(FUNC_DATA));
      drive_req(random_req(FUNC_UNUSED));

      // read across the top of the address space, with a page break at the wrap
      t = random_req(FUNC_START);
      t.start_address = 32'hFFFF_FFFE;
      t.length        = 32'd3;
      drive_req(t);
      t = random_req(FUNC_START);
      t.start_address = '1;
      t.length        = '1;
      drive_req(t);
      t = random_req(FUNC_DATA);
      t.data_byte = 8'h00;
      drive_req(t);
      t = random_req(FUNC_STATUS);
      t.ready_req = 1'b0;
      drive_req(t);
      t.ready_req = 1'b1;
      drive_req(t);
      drive_req(t);
      drive_req(random_req(FUNC_UNUSED));
      t = random_req(FUNC_DATA);
      t.data_byte = 8'h00;
      drive_req(t);
      t.data_byte = 8'hFF;
      drive_req(t);
      t = random_req(FUNC_STATUS);
      t.ready_req = 1'b1;
      drive_req(t);
      t = random_req(FUNC_DATA);
      t.data_byte = 8'h5A;
      drive_req(t);
      drain_results();

      // last byte lands exactly on a page end, then reads across a page end and from address zero
      read_sequence(32'(PAGE_BYTES - 1), 32'd1, 0);
      read_sequence(32'(PAGE_BYTES - 2), 32'd4, 0);
      read_sequence(32'h0000_0000, 32'd2, 0);
      drain_results();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= 120 && random_items < 200) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = 33;
            stall_pct = 33;
         end
         if ($urandom_range(99) < 15) send_noise(FUNC_START);
         addr = $urandom;
         case ($urandom_range(3))
            0: addr = addr - (addr % 32'(PAGE_BYTES)) + 32'(PAGE_BYTES)
                      - 32'($urandom_range(1, 8));
            1: addr = 32'hFFFF_FFFF - 32'($urandom_range(5));
            default: ;
         endcase
         len = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(1, 20));
         read_sequence(addr, len, 12);
         if ($urandom_range(7) == 0) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("nand_page_read_sequencer_unit verification clean");
      end else begin
         $display("nand_page_read_sequencer_unit verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/npr_pkg.sv
design/npr_emitter.sv
design/nand_page_read_sequencer_unit.sv
tb/npr_read_checker.sv
tb/nand_page_read_sequencer_unit_test.sv
